### rtl/ndc_pkg.sv
// ----------------------------------------------------------------------------
// ndc_pkg: shared types and calendar tables
// Field widths, date structs and month length / day-of-year lookups.
// ----------------------------------------------------------------------------
`default_nettype none

package ndc_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned DoyW   = 9;

  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;

  // floor(y / 100) == (y * Div100Mult) >> Div100Shift for every 14-bit y
  localparam int unsigned Div100Mult  = 5243;
  localparam int unsigned Div100Shift = 19;
  localparam int unsigned Div100MultW = 13;
  localparam int unsigned Div100ProdW = YearW + Div100MultW;
  localparam int unsigned CenturyW    = Div100ProdW - Div100Shift;

  typedef struct packed {
    logic [YearW-1:0]  cur_year;
    logic              year_known;
    logic [MonthW-1:0] cur_month;
    logic [DayW-1:0]   cur_day;
  } date_in_t;

  typedef struct packed {
    logic [YearW-1:0]  next_year;
    logic [MonthW-1:0] next_month;
    logic [DayW-1:0]   next_day;
    logic [DoyW-1:0]   next_day_of_year;
    logic [DayW-1:0]   month_days;
    logic              leap_flag;
    logic              bad_date;
  } date_out_t;

  // length of a month, 0 for a month code outside 1..12
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] month,
                                                input logic leap);
    logic [DayW-1:0] len;
    unique case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // days in the months before the given one, common year
  function automatic logic [DoyW-1:0] days_before(input logic [MonthW-1:0] month);
    logic [DoyW-1:0] d;
    unique case (month)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

### rtl/ndc_if.sv
// ----------------------------------------------------------------------------
// ndc_if: date channels
// Valid/ready channels for the input date and the next-day result.
// ----------------------------------------------------------------------------
`default_nettype none

interface ndc_in_if;
  import ndc_pkg::*;
  logic              valid;
  logic              ready;
  logic [YearW-1:0]  cur_year;
  logic              year_known;
  logic [MonthW-1:0] cur_month;
  logic [DayW-1:0]   cur_day;

  modport source (output valid, output cur_year, output year_known, output cur_month,
                  output cur_day, input ready);
  modport sink   (input valid, input cur_year, input year_known, input cur_month,
                  input cur_day, output ready);
endinterface

interface ndc_out_if;
  import ndc_pkg::*;
  logic              valid;
  logic              ready;
  logic [YearW-1:0]  next_year;
  logic [MonthW-1:0] next_month;
  logic [DayW-1:0]   next_day;
  logic [DoyW-1:0]   next_day_of_year;
  logic [DayW-1:0]   month_days;
  logic              leap_flag;
  logic              bad_date;

  modport source (output valid, output next_year, output next_month, output next_day,
                  output next_day_of_year, output month_days, output leap_flag,
                  output bad_date, input ready);
  modport sink   (input valid, input next_year, input next_month, input next_day,
                  input next_day_of_year, input month_days, input leap_flag,
                  input bad_date, output ready);
endinterface

`default_nettype wire

### rtl/ndc_date_calc.sv
// ----------------------------------------------------------------------------
// ndc_date_calc: next-day arithmetic
// Leap rule, month length, rollover and day-of-year for one date.
// ----------------------------------------------------------------------------
`default_nettype none

module ndc_date_calc
  import ndc_pkg::*;
(
  input  date_in_t  date_i,
  output date_out_t result_o
);

  logic [Div100ProdW-1:0] prod;
  logic [CenturyW-1:0]    cent;
  logic [YearW-1:0]       cent_x100;
  logic                   is_century;
  logic                   leap;
  logic [DayW-1:0]        mlen;
  logic                   bad;
  logic                   month_end;
  logic                   year_end;
  logic [MonthW-1:0]      nm;
  logic [DayW-1:0]        nd;
  logic [YearW-1:0]       ny;
  logic [DoyW-1:0]        doy;

  // year / 100 by reciprocal; century when the quotient times 100 gives it back
  assign prod       = Div100ProdW'(date_i.cur_year) * Div100ProdW'(Div100Mult);
  assign cent       = prod[Div100ProdW-1:Div100Shift];
  assign cent_x100  = YearW'({cent, 6'b0}) + YearW'({cent, 5'b0}) + YearW'({cent, 2'b0});
  assign is_century = (cent_x100 == date_i.cur_year);

  assign leap = date_i.year_known &
                (is_century ? (cent[1:0] == 2'b00) : (date_i.cur_year[1:0] == 2'b00));

  assign mlen = month_len(date_i.cur_month, leap);
  assign bad  = (mlen == '0) || (date_i.cur_day == '0) || (date_i.cur_day > mlen);

  assign month_end = (date_i.cur_day == mlen);
  assign year_end  = month_end && (date_i.cur_month == MonthDec);

  always_comb begin
    nd = month_end ? DayW'(1) : date_i.cur_day + DayW'(1);
    priority if (year_end) begin
      nm = MonthJan;
    end else if (month_end) begin
      nm = date_i.cur_month + MonthW'(1);
    end else begin
      nm = date_i.cur_month;
    end
    ny  = (year_end && date_i.year_known) ? date_i.cur_year + YearW'(1) : date_i.cur_year;
    doy = days_before(nm) + DoyW'(leap && (nm > MonthFeb)) + DoyW'(nd);
  end

  always_comb begin
    result_o.month_days = mlen;
    result_o.leap_flag  = leap;
    result_o.bad_date   = bad;
    if (bad) begin
      result_o.next_year        = '0;
      result_o.next_month       = '0;
      result_o.next_day         = '0;
      result_o.next_day_of_year = '0;
    end else begin
      result_o.next_year        = ny;
      result_o.next_month       = nm;
      result_o.next_day         = nd;
      result_o.next_day_of_year = doy;
    end
  end

endmodule

`default_nettype wire

### rtl/next_calendar_day.sv
// ----------------------------------------------------------------------------
// next_calendar_day: Gregorian next-day unit
// Input register, date arithmetic, result register; one date per cycle unless the result stalls.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake      payload
//  req_i     in    valid/ready    cur_year, year_known, cur_month, cur_day
//  rsp_o     out   valid/ready    next_year .. bad_date
//
// The input date is registered, passes the calc stage and is registered again
// before it can transfer out; throughput is one date per cycle while the result
// side accepts, set by the single calc stage between the input and result
// registers. Reset empties both stages. A stalled result holds its register;
// the input stage keeps accepting while it is empty or can move on.
//
`default_nettype none

module next_calendar_day
  import ndc_pkg::*;
(
  input  wire    clk_i,
  input  wire    rst_ni,
  ndc_in_if.sink   req_i,
  ndc_out_if.source rsp_o
);

  logic      in_valid_q;
  date_in_t  in_q;
  date_in_t  in_d;
  logic      out_valid_q;
  date_out_t out_q;
  date_out_t calc;
  logic      out_load;
  logic      in_load;

  assign out_load = !out_valid_q || rsp_o.ready;
  assign in_load  = !in_valid_q || out_load;

  assign req_i.ready = in_load;

  assign in_d.cur_year   = req_i.cur_year;
  assign in_d.year_known = req_i.year_known;
  assign in_d.cur_month  = req_i.cur_month;
  assign in_d.cur_day    = req_i.cur_day;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_load) begin
        in_valid_q <= req_i.valid;
      end
      if (out_load) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && req_i.valid) begin
      in_q <= in_d;
    end
    if (out_load && in_valid_q) begin
      out_q <= calc;
    end
  end

  ndc_date_calc u_calc (
    .date_i   (in_q),
    .result_o (calc)
  );

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.next_year        = out_q.next_year;
  assign rsp_o.next_month       = out_q.next_month;
  assign rsp_o.next_day         = out_q.next_day;
  assign rsp_o.next_day_of_year = out_q.next_day_of_year;
  assign rsp_o.month_days       = out_q.month_days;
  assign rsp_o.leap_flag        = out_q.leap_flag;
  assign rsp_o.bad_date         = out_q.bad_date;

  // a bad date never carries a date
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.bad_date |->
      out_q.next_year == '0 && out_q.next_month == '0 &&
      out_q.next_day == '0 && out_q.next_day_of_year == '0)
    else $error("bad date result carries a date");

  // a good date lands in a real month with a sane ordinal
  a_good_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.bad_date |->
      out_q.next_month >= MonthJan && out_q.next_month <= MonthDec &&
      out_q.next_day != '0 && out_q.next_day_of_year != '0 &&
      out_q.next_day_of_year <= DoyW'(366))
    else $error("good date result out of range");

  // an item in the input stage moves on whenever the result stage can take it
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_load |=> out_valid_q)
    else $error("input stage item lost");

endmodule

`default_nettype wire

### tb/sv/next_day_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_day_checker: result checker for next_calendar_day
// Computes the following date for every input transfer and compares each
// result transfer against the oldest outstanding date, field by field.
// ----------------------------------------------------------------------------

module next_day_checker
  import ndc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  ndc_in_if    req_i,
  ndc_out_if   rsp_i,
  output int   fail_cnt_o,
  output int   pending_o
);

  localparam logic [DayW-1:0] CommonLen [1:12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  date_out_t due_dates[$];
  int        errors = 0;

  function automatic logic [DayW-1:0] days_in(input logic [MonthW-1:0] month,
                                              input logic leap);
    if (month < MonthJan || month > MonthDec) return '0;
    return CommonLen[month] + ((month == MonthFeb) ? leap : 1'b0);
  endfunction

  function automatic date_out_t next_date_of(input date_in_t d);
    date_out_t         r;
    logic              leap;
    logic [DayW-1:0]   len;
    logic [MonthW-1:0] nm;
    logic [DayW:0]     nd;
    int unsigned       doy;
    int                m;
    r = '0;
    // centuries are leap only every fourth one; unknown years never
    if (!d.year_known) leap = 1'b0;
    else if (d.cur_year % 100 == 0) leap = ((d.cur_year / 100) % 4) == 0;
    else leap = (d.cur_year % 4) == 0;
    len = days_in(d.cur_month, leap);
    r.month_days = len;
    r.leap_flag  = leap;
    if (len == 0 || d.cur_day == 0 || d.cur_day > len) begin
      r.bad_date = 1'b1;
      return r;
    end
    r.next_year = d.cur_year;
    nm = d.cur_month;
    nd = {1'b0, d.cur_day} + 6'd1;
    if (nd > {1'b0, len}) begin
      nd = 6'd1;
      if (nm == MonthDec) begin
        nm = MonthJan;
        if (d.year_known) r.next_year = d.cur_year + 1'b1;  // wraps at 14 bits
      end else begin
        nm = nm + 1'b1;
      end
    end
    doy = 32'(nd);
    for (m = 1; m < int'(nm); m++) doy += 32'(days_in(MonthW'(m), leap));
    r.next_month       = nm;
    r.next_day         = nd[DayW-1:0];
    r.next_day_of_year = doy[DoyW-1:0];
    return r;
  endfunction

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    date_in_t  din;
    date_out_t want;
    if (rst_ni) begin
      if (req_i.valid && req_i.ready) begin
        din.cur_year   = req_i.cur_year;
        din.year_known = req_i.year_known;
        din.cur_month  = req_i.cur_month;
        din.cur_day    = req_i.cur_day;
        due_dates.push_back(next_date_of(din));
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (due_dates.size() == 0) begin
          errors++;
          $display("%0t: result expected none, got %0d-%0d-%0d bad %0d", $time,
                   rsp_i.next_year, rsp_i.next_month, rsp_i.next_day, rsp_i.bad_date);
        end else begin
          want = due_dates.pop_front();
          check_field("next_year", 32'(want.next_year), 32'(rsp_i.next_year));
          check_field("next_month", 32'(want.next_month), 32'(rsp_i.next_month));
          check_field("next_day", 32'(want.next_day), 32'(rsp_i.next_day));
          check_field("next_day_of_year", 32'(want.next_day_of_year),
                      32'(rsp_i.next_day_of_year));
          check_field("month_days", 32'(want.month_days), 32'(rsp_i.month_days));
          check_field("leap_flag", 32'(want.leap_flag), 32'(rsp_i.leap_flag));
          check_field("bad_date", 32'(want.bad_date), 32'(rsp_i.bad_date));
        end
      end
    end
    pending_o  <= due_dates.size();
    fail_cnt_o <= errors;
  end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for next_calendar_day
// Drives directed calendar corner dates, then random dates with random gaps
// and result back-pressure; the checker predicts and compares every result.
// ----------------------------------------------------------------------------

module tb;
  import ndc_pkg::*;

  localparam int RandomDates = 1950;
  localparam int HoldAt      = 600;
  localparam int DrainAt     = 1200;
  localparam int HoldCycles  = 400;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  bit   hold_rx = 1'b0;
  int   fail_cnt;
  int   pending;

  ndc_in_if  req ();
  ndc_out_if rsp ();

  next_calendar_day dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  next_day_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .rsp_i      (rsp),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // mostly short, now and then long
  function automatic int stretch_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic date_in_t mk_date(input int year, input bit known, input int month,
                                       input int day);
    date_in_t d;
    d.cur_year   = YearW'(year);
    d.year_known = known;
    d.cur_month  = MonthW'(month);
    d.cur_day    = DayW'(day);
    return d;
  endfunction

  function automatic date_in_t random_date();
    date_in_t d;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) d.cur_year = YearW'($urandom_range(0, 16383));
    else if (pick < 60) d.cur_year = YearW'($urandom_range(0, 163) * 100 + $urandom_range(0, 4));
    else if (pick < 85) d.cur_year = YearW'($urandom_range(1896, 2104));
    else if (pick < 93) d.cur_year = YearW'($urandom_range(16370, 16383));
    else d.cur_year = YearW'($urandom_range(0, 8));
    d.year_known = ($urandom_range(0, 3) != 0);
    // mostly well-formed dates, leaning on month ends
    d.cur_month = ($urandom_range(0, 9) == 0) ? MonthW'($urandom_range(0, 15))
                                              : MonthW'($urandom_range(1, 12));
    pick = $urandom_range(0, 99);
    if (pick < 45) d.cur_day = DayW'($urandom_range(1, 28));
    else if (pick < 90) d.cur_day = DayW'($urandom_range(28, 31));
    else d.cur_day = DayW'($urandom_range(0, 31));
    return d;
  endfunction

  // called at a rising edge; returns at the edge of the transfer
  task automatic offer_date(input date_in_t d);
    req.valid      <= 1'b1;
    req.cur_year   <= d.cur_year;
    req.year_known <= d.year_known;
    req.cur_month  <= d.cur_month;
    req.cur_day    <= d.cur_day;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
  endtask

  task automatic drain_results();
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int gap;
    req.valid      <= 1'b0;
    req.cur_year   <= '0;
    req.year_known <= 1'b0;
    req.cur_month  <= '0;
    req.cur_day    <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    offer_date(mk_date(2023, 1, 1, 1));
    offer_date(mk_date(2023, 1, 1, 31));
    offer_date(mk_date(2023, 1, 2, 28));
    offer_date(mk_date(2024, 1, 2, 28));
    offer_date(mk_date(2024, 1, 2, 29));
    offer_date(mk_date(2023, 1, 2, 29));
    offer_date(mk_date(1900, 1, 2, 28));
    offer_date(mk_date(1900, 1, 2, 29));
    offer_date(mk_date(2000, 1, 2, 29));
    offer_date(mk_date(2024, 0, 2, 28));
    offer_date(mk_date(2024, 0, 2, 29));
    offer_date(mk_date(2023, 1, 4, 30));
    offer_date(mk_date(2023, 1, 4, 31));
    offer_date(mk_date(2023, 1, 12, 31));
    offer_date(mk_date(2024, 0, 12, 31));
    offer_date(mk_date(2024, 1, 12, 30));
    offer_date(mk_date(16383, 1, 12, 31));
    offer_date(mk_date(16383, 0, 12, 31));
    offer_date(mk_date(9999, 1, 12, 30));
    offer_date(mk_date(0, 1, 2, 29));
    offer_date(mk_date(2023, 1, 0, 15));
    offer_date(mk_date(2023, 1, 13, 1));
    offer_date(mk_date(2023, 1, 15, 31));
    offer_date(mk_date(2023, 1, 6, 0));
    offer_date(mk_date(2400, 1, 2, 29));
    drain_results();

    for (int i = 0; i < RandomDates; i++) begin
      if (i == HoldAt) hold_rx = 1'b1;
      if (i == DrainAt) drain_results();
      // back-to-back while the result side is held so the pipe fills up
      if (i >= HoldAt && i < HoldAt + 60) gap = 0;
      else gap = ($urandom_range(0, 1) == 0) ? 0 : stretch_len();
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      offer_date(random_date());
    end
    drain_results();
    repeat (8) @(posedge clk_i);

    if (fail_cnt == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // result side: alternating runs of ready and stalls, one long hold-off
  initial begin
    int stall_left;
    int run_left;
    bit held;
    stall_left = 0;
    run_left   = 0;
    held       = 1'b0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_rx && !held) begin
        held       = 1'b1;
        stall_left = HoldCycles;
        run_left   = 0;
      end
      if (stall_left == 0 && run_left == 0) begin
        stall_left = ($urandom_range(0, 2) == 0) ? stretch_len() : 0;
        run_left   = stretch_len();
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else begin
        run_left--;
        rsp.ready <= 1'b1;
      end
    end
  end

  initial begin
    #15_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
